// ===== rtl/core/mjs_pkg.sv =====
// Shared constants, register codes and store control type of the sample grid.
`default_nettype none

package mjs_pkg;

    // Grid and number format
    localparam int MAX_COLS  = 16;
    localparam int MAX_ROWS  = 16;
    localparam int FRAC_BITS = 16;
    localparam int OUT_BITS  = 24;

    // Derived widths
    localparam int IDX_W   = 4;                       // column / row index
    localparam int SIZE_W  = 5;                       // m and n, 1..16
    localparam int ADDR_W  = 8;                       // store address
    localparam int DEPTH   = MAX_COLS * MAX_ROWS;
    localparam int CELL_W  = 9;                       // m*n, up to 256
    localparam int CNT_W   = 10;                      // feed counter
    localparam int NUM_W   = ADDR_W + OUT_BITS;       // dividend width
    localparam int SHIFT_W = OUT_BITS - FRAC_BITS;    // extra fraction bits
    localparam int CFG_W   = 5;                       // widest register
    localparam int CIDX_W  = 2;                       // register index

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_COLS   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_ROWS   = 2'd1;
    localparam logic [CIDX_W-1:0] REG_JITTER = 2'd2;

    // Operation codes
    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    // One half in Q0.FRAC_BITS
    localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

    // Control of the two coordinate stores
    typedef struct packed {
        logic                re;
        logic [ADDR_W-1:0]   ra_a;
        logic [ADDR_W-1:0]   ra_b;
        logic                we_x;
        logic                we_y;
        logic [ADDR_W-1:0]   wa;
        logic [OUT_BITS-1:0] wd;
    } store_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/mjs_if.sv =====
// Request and response channel interfaces of the sample grid.
`default_nettype none

interface mjs_req_if
    import mjs_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [FRAC_BITS-1:0] random_fraction;
    logic [IDX_W-1:0]     col;
    logic [IDX_W-1:0]     row;

    modport source (output valid, output op, output random_fraction, output col,
                    output row, input ready);
    modport sink   (input valid, input op, input random_fraction, input col,
                    input row, output ready);
endinterface

interface mjs_rsp_if
    import mjs_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] point_x;
    logic [OUT_BITS-1:0] point_y;
    logic                set_complete;

    modport source (output valid, output point_x, output point_y,
                    output set_complete, input ready);
    modport sink   (input valid, input point_x, input point_y,
                    input set_complete, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mjs_div.sv =====
// Restoring divider, one quotient bit per cycle, for grid coordinates.
`default_nettype none

module mjs_div
    import mjs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NUM_W-1:0]    num,
    input  wire logic [CELL_W-1:0]   den,
    output logic                     done,
    output logic [OUT_BITS-1:0]      quo
);

    localparam int REM_W  = CELL_W - 1;
    localparam int STEP_W = $clog2(NUM_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [NUM_W-1:0]    work_reg, work_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [CELL_W-1:0]   den_reg, den_next;
    logic [CELL_W-1:0]   trial;
    logic                fits;

    // Shift one dividend bit into the remainder and try the subtract
    always_comb
    begin
        trial     = {rem_reg, work_reg[NUM_W-1]};
        fits      = (trial >= den_reg);
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            work_next = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? REM_W'(trial - den_reg) : trial[REM_W-1:0];
            work_next = {work_reg[NUM_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control under reset, datapath without
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quo  = work_reg[OUT_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/mjs_store.sv =====
// Coordinate stores: x and y memories, two registered read ports, one write port.
`default_nettype none

module mjs_store
    import mjs_pkg::*;
(
    input  wire logic                clk,
    input  wire store_ctl_t          ctl,
    output logic [OUT_BITS-1:0]      x_a,
    output logic [OUT_BITS-1:0]      x_b,
    output logic [OUT_BITS-1:0]      y_a,
    output logic [OUT_BITS-1:0]      y_b
);

    logic [OUT_BITS-1:0] x_mem [DEPTH];
    logic [OUT_BITS-1:0] y_mem [DEPTH];

    // Write one coordinate
    always_ff @(posedge clk)
    begin
        if (ctl.we_x)
        begin
            x_mem[ctl.wa] <= ctl.wd;
        end
        if (ctl.we_y)
        begin
            y_mem[ctl.wa] <= ctl.wd;
        end
    end

    // Read both ports, hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (ctl.re)
        begin
            x_a <= x_mem[ctl.ra_a];
            x_b <= x_mem[ctl.ra_b];
            y_a <= y_mem[ctl.ra_a];
            y_b <= y_mem[ctl.ra_b];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/multi_jittered_sample_grid_unit.sv =====
// Top level of the multi-jittered sample grid: sequencer, registers and output stage.
`default_nettype none

// Builds an m x n multi-jittered sample set from fed random fractions and serves
// point reads. One item is in work at a time; req.ready is high only while idle.
// A read passes through dispatch, store read and output load to its result beat,
// and waits in output load while the previous result has not been taken. A fill
// feed waits on the 32-step restoring divider that divides by m*n. A shuffle
// feed swaps x along a row or y along a column: each pair is read in ST_SW_RD
// and written back in ST_SW_WA and ST_SW_WB on the single store write port.
// Feeds produce no result beat and may be accepted while a result beat still
// waits. There is no clearing pass after reset.
module multi_jittered_sample_grid_unit
    import mjs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    mjs_req_if.sink                 req,
    mjs_rsp_if.source               rsp,
    input  wire logic               cfg_we,
    input  wire logic [CIDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DISP   = 4'd1;
    localparam logic [3:0] ST_DIV    = 4'd2;
    localparam logic [3:0] ST_SW_RD  = 4'd3;
    localparam logic [3:0] ST_SW_WA  = 4'd4;
    localparam logic [3:0] ST_SW_WB  = 4'd5;
    localparam logic [3:0] ST_RD_OUT = 4'd6;

    // a*b + c for grid addresses; always below the store depth
    function automatic logic [ADDR_W-1:0] grid_addr(
        input logic [IDX_W-1:0]  a,
        input logic [SIZE_W-1:0] b,
        input logic [IDX_W-1:0]  c
    );
        logic [ADDR_W:0] p;
        p = (ADDR_W+1)'(a) * (ADDR_W+1)'(b) + (ADDR_W+1)'(c);
        return p[ADDR_W-1:0];
    endfunction

    // Swap partner: base + floor(r * (size - base))
    function automatic logic [IDX_W-1:0] swap_partner(
        input logic [IDX_W-1:0]     base,
        input logic [FRAC_BITS-1:0] r,
        input logic [SIZE_W-1:0]    size
    );
        logic [SIZE_W-1:0]           span;
        logic [FRAC_BITS+SIZE_W-1:0] p;
        logic [SIZE_W-1:0]           k;
        span = size - SIZE_W'(base);
        p    = (FRAC_BITS+SIZE_W)'(r) * (FRAC_BITS+SIZE_W)'(span);
        k    = SIZE_W'(base) + p[FRAC_BITS+SIZE_W-1:FRAC_BITS];
        return k[IDX_W-1:0];
    endfunction

    logic [3:0]           state_reg, state_next;
    logic [SIZE_W-1:0]    cols_reg, cols_next;
    logic [SIZE_W-1:0]    rows_reg, rows_next;
    logic                 jitter_reg, jitter_next;
    logic [CNT_W-1:0]     feed_cnt_reg, feed_cnt_next;
    logic                 complete_reg, complete_next;
    logic [IDX_W-1:0]     ci_reg, ci_next;
    logic [IDX_W-1:0]     cj_reg, cj_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic                 op_reg, op_next;
    logic [FRAC_BITS-1:0] r_reg, r_next;
    logic [IDX_W-1:0]     col_reg, col_next;
    logic [IDX_W-1:0]     row_reg, row_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic                 fill_y_reg, fill_y_next;
    logic                 shuf_y_reg, shuf_y_next;
    logic [IDX_W-1:0]     lo_reg, lo_next;
    logic [IDX_W-1:0]     hi_reg, hi_next;
    logic [IDX_W-1:0]     t_reg, t_next;
    logic                 in_grid_reg, in_grid_next;
    logic [OUT_BITS-1:0]  px_reg, px_next;
    logic [OUT_BITS-1:0]  py_reg, py_next;
    logic                 sc_reg, sc_next;

    logic [SIZE_W-1:0]    m_eff;
    logic [SIZE_W-1:0]    n_eff;
    logic [CELL_W-1:0]    cells;
    logic [CNT_W-1:0]     fill_end;
    logic [CNT_W-1:0]     total;
    logic [CNT_W-1:0]     f_eff;
    logic [CNT_W-1:0]     f_inc;
    logic [CNT_W-1:0]     x_off;
    logic [CNT_W-1:0]     y_off;
    logic [IDX_W-1:0]     ci_e;
    logic [IDX_W-1:0]     cj_e;
    logic [ADDR_W-1:0]    pos;
    logic [ADDR_W-1:0]    sw_a;
    logic [ADDR_W-1:0]    sw_b;
    logic [SIZE_W-1:0]    sw_len;
    logic [2*SIZE_W-1:0]  cells_full;

    logic                 div_start;
    logic [NUM_W-1:0]     div_num;
    logic                 div_done;
    logic [OUT_BITS-1:0]  div_quo;

    store_ctl_t           st_ctl;
    logic [OUT_BITS-1:0]  x_a, x_b, y_a, y_b;

    // Clamp the grid size and derive the phase boundaries
    always_comb
    begin
        m_eff = (cols_reg == '0) ? SIZE_W'(1) :
                (cols_reg > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : cols_reg;
        n_eff = (rows_reg == '0) ? SIZE_W'(1) :
                (rows_reg > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : rows_reg;
        cells_full = (2*SIZE_W)'(m_eff) * (2*SIZE_W)'(n_eff);
        cells      = cells_full[CELL_W-1:0];
        fill_end   = {cells, 1'b0};
        total      = fill_end + CNT_W'(n_eff) + CNT_W'(m_eff);
    end

    // A feed after completion starts a new set
    always_comb
    begin
        f_eff = complete_reg ? '0 : feed_cnt_reg;
        ci_e  = complete_reg ? '0 : ci_reg;
        cj_e  = complete_reg ? '0 : cj_reg;
        f_inc = f_eff + 1'b1;
        x_off = f_eff - fill_end;
        y_off = f_eff - fill_end - CNT_W'(n_eff);
        pos   = f_eff[0] ? grid_addr(cj_e, m_eff, ci_e) : grid_addr(ci_e, n_eff, cj_e);
        div_num = {pos, r_reg, {SHIFT_W{1'b0}}};
    end

    // Swap addresses for the current step of a shuffle
    always_comb
    begin
        if (shuf_y_reg)
        begin
            sw_a   = grid_addr(t_reg, m_eff, lo_reg);
            sw_b   = grid_addr(t_reg, m_eff, hi_reg);
            sw_len = n_eff;
        end
        else
        begin
            sw_a   = grid_addr(lo_reg, m_eff, t_reg);
            sw_b   = grid_addr(hi_reg, m_eff, t_reg);
            sw_len = m_eff;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        jitter_next    = jitter_reg;
        feed_cnt_next  = feed_cnt_reg;
        complete_next  = complete_reg;
        ci_next        = ci_reg;
        cj_next        = cj_reg;
        rsp_valid_next = rsp_valid_reg;
        op_next        = op_reg;
        r_next         = r_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        addr_next      = addr_reg;
        fill_y_next    = fill_y_reg;
        shuf_y_next    = shuf_y_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        t_next         = t_reg;
        in_grid_next   = in_grid_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        sc_next        = sc_reg;
        div_start      = 1'b0;
        st_ctl         = '0;

        // Drop the result once taken
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.op;
                    r_next     = jitter_reg ? req.random_fraction : HALF;
                    col_next   = req.col;
                    row_next   = req.row;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                if (op_reg == OP_READ)
                begin
                    st_ctl.re    = 1'b1;
                    st_ctl.ra_a  = grid_addr(row_reg, m_eff, col_reg);
                    st_ctl.ra_b  = st_ctl.ra_a;
                    in_grid_next = (SIZE_W'(col_reg) < m_eff) && (SIZE_W'(row_reg) < n_eff);
                    state_next   = ST_RD_OUT;
                end
                else
                begin
                    feed_cnt_next = f_inc;
                    complete_next = (f_inc >= total);
                    ci_next       = ci_e;
                    cj_next       = cj_e;
                    t_next        = '0;
                    if (f_eff < fill_end)
                    begin
                        // Fill one coordinate of the current cell
                        addr_next   = grid_addr(cj_e, m_eff, ci_e);
                        fill_y_next = f_eff[0];
                        div_start   = 1'b1;
                        if (f_eff[0])
                        begin
                            if (SIZE_W'(ci_e) + 1'b1 == m_eff)
                            begin
                                ci_next = '0;
                                cj_next = cj_e + 1'b1;
                            end
                            else
                            begin
                                ci_next = ci_e + 1'b1;
                            end
                        end
                        state_next = ST_DIV;
                    end
                    else if (f_eff < fill_end + CNT_W'(n_eff))
                    begin
                        // Shuffle x between two rows
                        shuf_y_next = 1'b0;
                        lo_next     = x_off[IDX_W-1:0];
                        hi_next     = swap_partner(x_off[IDX_W-1:0], r_reg, n_eff);
                        state_next  = ST_SW_RD;
                    end
                    else
                    begin
                        // Shuffle y between two columns
                        shuf_y_next = 1'b1;
                        lo_next     = y_off[IDX_W-1:0];
                        hi_next     = swap_partner(y_off[IDX_W-1:0], r_reg, m_eff);
                        state_next  = ST_SW_RD;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    st_ctl.we_x = !fill_y_reg;
                    st_ctl.we_y = fill_y_reg;
                    st_ctl.wa   = addr_reg;
                    st_ctl.wd   = div_quo;
                    state_next  = ST_IDLE;
                end
            end
            ST_SW_RD:
            begin
                st_ctl.re   = 1'b1;
                st_ctl.ra_a = sw_a;
                st_ctl.ra_b = sw_b;
                state_next  = ST_SW_WA;
            end
            ST_SW_WA:
            begin
                st_ctl.we_x = !shuf_y_reg;
                st_ctl.we_y = shuf_y_reg;
                st_ctl.wa   = sw_a;
                st_ctl.wd   = shuf_y_reg ? y_b : x_b;
                state_next  = ST_SW_WB;
            end
            ST_SW_WB:
            begin
                st_ctl.we_x = !shuf_y_reg;
                st_ctl.we_y = shuf_y_reg;
                st_ctl.wa   = sw_b;
                st_ctl.wd   = shuf_y_reg ? y_a : x_a;
                if (SIZE_W'(t_reg) + 1'b1 == sw_len)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    t_next     = t_reg + 1'b1;
                    state_next = ST_SW_RD;
                end
            end
            ST_RD_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    px_next        = in_grid_reg ? x_a : '0;
                    py_next        = in_grid_reg ? y_a : '0;
                    sc_next        = complete_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // The user must make configuration writes only while idle; the block does not enforce it
        if (cfg_we)
        begin
            case (cfg_index)
                REG_COLS:
                begin
                    cols_next     = cfg_data;
                    feed_cnt_next = '0;
                    complete_next = 1'b0;
                    ci_next       = '0;
                    cj_next       = '0;
                end
                REG_ROWS:
                begin
                    rows_next     = cfg_data;
                    feed_cnt_next = '0;
                    complete_next = 1'b0;
                    ci_next       = '0;
                    cj_next       = '0;
                end
                REG_JITTER:
                begin
                    jitter_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cols_reg      <= SIZE_W'(MAX_COLS);
            rows_reg      <= SIZE_W'(MAX_ROWS);
            jitter_reg    <= 1'b1;
            feed_cnt_reg  <= '0;
            complete_reg  <= 1'b0;
            ci_reg        <= '0;
            cj_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
            jitter_reg    <= jitter_next;
            feed_cnt_reg  <= feed_cnt_next;
            complete_reg  <= complete_next;
            ci_reg        <= ci_next;
            cj_reg        <= cj_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        r_reg       <= r_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        addr_reg    <= addr_next;
        fill_y_reg  <= fill_y_next;
        shuf_y_reg  <= shuf_y_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        t_reg       <= t_next;
        in_grid_reg <= in_grid_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        sc_reg      <= sc_next;
    end

    mjs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (cells),
        .done  (div_done),
        .quo   (div_quo)
    );

    mjs_store u_store (
        .clk (clk),
        .ctl (st_ctl),
        .x_a (x_a),
        .x_b (x_b),
        .y_a (y_a),
        .y_b (y_b)
    );

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.point_x      = px_reg;
    assign rsp.point_y      = py_reg;
    assign rsp.set_complete = sc_reg;

`ifndef ASSERT_OFF
    a_complete_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        complete_reg |-> (feed_cnt_reg == total))
        else $error("set marked complete away from the last feed");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        feed_cnt_reg <= total)
        else $error("feed counter past the end of the set");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SIZE_W'(ci_reg) < m_eff)
        else $error("fill column counter outside the grid");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        (st_ctl.we_x || st_ctl.we_y) |->
        (state_reg == ST_DIV || state_reg == ST_SW_WA || state_reg == ST_SW_WB))
        else $error("store written outside a fill or swap step");

    a_div_result: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside a fill");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the multi-jittered sample grid unit.

module tb_top
    import mjs_pkg::*;
;

    localparam int SETTLE_CYCLES = 80;          // longest feed is a 16-wide shuffle
    localparam int LIMIT_NS      = 1_000_000;
    localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [OUT_BITS-1:0] x;
        logic [OUT_BITS-1:0] y;
        logic                set_complete;
    } grid_point_t;

    // Shadow of the sample set: registers, both coordinate stores and the feed sequencer
    class point_scoreboard;
        logic [SIZE_W-1:0]   cols_reg;
        logic [SIZE_W-1:0]   rows_reg;
        logic                jitter_on;
        logic [OUT_BITS-1:0] x_mem [DEPTH];
        logic [OUT_BITS-1:0] y_mem [DEPTH];
        bit                  x_set [DEPTH];
        bit                  y_set [DEPTH];
        int unsigned         feeds;
        bit                  complete;
        grid_point_t         expected_points [$];
        int                  errors;

        function new();
            cols_reg  = 5'd16;
            rows_reg  = 5'd16;
            jitter_on = 1'b1;
            feeds     = 0;
            complete  = 1'b0;
            errors    = 0;
            foreach (x_set[a])
            begin
                x_set[a] = 1'b0;
                y_set[a] = 1'b0;
            end
        endfunction

        function int unsigned cols();
            if (cols_reg == 0) return 1;
            if (cols_reg > MAX_COLS) return MAX_COLS;
            return cols_reg;
        endfunction

        function int unsigned rows();
            if (rows_reg == 0) return 1;
            if (rows_reg > MAX_ROWS) return MAX_ROWS;
            return rows_reg;
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        // A read is legal unless it hits a grid cell not yet written since reset
        function bit readable(logic [IDX_W-1:0] c, logic [IDX_W-1:0] r);
            int unsigned a;
            if (c >= cols() || r >= rows()) return 1'b1;
            a = r * cols() + c;
            return x_set[a] && y_set[a];
        endfunction

        // floor((pos + frac) / cells) in Q0.24
        function logic [OUT_BITS-1:0] grid_coord(int unsigned pos, logic [FRAC_BITS-1:0] frac,
                                                 int unsigned cells);
            longint unsigned num;
            num = pos;
            num = ((num << FRAC_BITS) + frac) << SHIFT_W;
            return OUT_BITS'(num / cells);
        endfunction

        function void swap_cells(bit x_side, int unsigned a, int unsigned b);
            logic [OUT_BITS-1:0] v;
            bit                  s;
            if (x_side)
            begin
                v = x_mem[a]; x_mem[a] = x_mem[b]; x_mem[b] = v;
                s = x_set[a]; x_set[a] = x_set[b]; x_set[b] = s;
            end
            else
            begin
                v = y_mem[a]; y_mem[a] = y_mem[b]; y_mem[b] = v;
                s = y_set[a]; y_set[a] = y_set[b]; y_set[b] = s;
            end
        endfunction

        function void apply_feed(logic [FRAC_BITS-1:0] frac);
            int unsigned m, n, cells, fill_end, c, i, j, k, t, fr;
            m        = cols();
            n        = rows();
            cells    = m * n;
            fill_end = 2 * cells;
            if (!jitter_on) frac = HALF;
            fr = frac;
            // A feed after completion starts a new set
            if (complete)
            begin
                complete = 1'b0;
                feeds    = 0;
            end
            if (feeds < fill_end)
            begin
                c = feeds >> 1;
                j = c / m;
                i = c % m;
                if (feeds % 2 == 0)
                begin
                    x_mem[c] = grid_coord(i * n + j, frac, cells);
                    x_set[c] = 1'b1;
                end
                else
                begin
                    y_mem[c] = grid_coord(j * m + i, frac, cells);
                    y_set[c] = 1'b1;
                end
            end
            else if (feeds < fill_end + n)
            begin
                j = feeds - fill_end;
                k = j + ((fr * (n - j)) >> FRAC_BITS);
                for (t = 0; t < m; t++)
                    swap_cells(1'b1, j * m + t, k * m + t);
            end
            else if (feeds < fill_end + n + m)
            begin
                i = feeds - fill_end - n;
                k = i + ((fr * (m - i)) >> FRAC_BITS);
                for (t = 0; t < n; t++)
                    swap_cells(1'b0, t * m + i, t * m + k);
            end
            feeds++;
            if (feeds >= fill_end + n + m) complete = 1'b1;
        endfunction

        // Note one accepted request beat
        function void note_item(logic op, logic [FRAC_BITS-1:0] frac,
                                logic [IDX_W-1:0] c, logic [IDX_W-1:0] r);
            grid_point_t p;
            int unsigned a;
            if (op == OP_FEED)
            begin
                apply_feed(frac);
                return;
            end
            p.x            = '0;
            p.y            = '0;
            p.set_complete = complete;
            if (c < cols() && r < rows())
            begin
                a   = r * cols() + c;
                p.x = x_mem[a];
                p.y = y_mem[a];
            end
            expected_points.push_back(p);
        endfunction

        function void note_config(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_COLS:
                begin
                    cols_reg = data;
                    feeds    = 0;
                    complete = 1'b0;
                end
                REG_ROWS:
                begin
                    rows_reg = data;
                    feeds    = 0;
                    complete = 1'b0;
                end
                REG_JITTER: jitter_on = data[0];
                default: ;
            endcase
        endfunction

        // Check one accepted result beat against the oldest waiting read
        function void check_point(logic [OUT_BITS-1:0] x, logic [OUT_BITS-1:0] y, logic done);
            grid_point_t p;
            if (expected_points.size() == 0)
            begin
                $display("%0t: result beat with no read waiting: x %h y %h complete %b",
                         $time, x, y, done);
                errors++;
                return;
            end
            p = expected_points.pop_front();
            if (x !== p.x)
            begin
                $display("%0t: point_x mismatch, expected %h, actual %h", $time, p.x, x);
                errors++;
            end
            if (y !== p.y)
            begin
                $display("%0t: point_y mismatch, expected %h, actual %h", $time, p.y, y);
                errors++;
            end
            if (done !== p.set_complete)
            begin
                $display("%0t: set_complete mismatch, expected %b, actual %b",
                         $time, p.set_complete, done);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [CIDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    int                 req_calm;
    int                 rsp_calm;
    point_scoreboard    grid = new();

    mjs_req_if req_ch ();
    mjs_rsp_if rsp_ch ();

    multi_jittered_sample_grid_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Draw an idle gap; now and then run a stretch with no gaps at all
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 40);
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [FRAC_BITS-1:0] pick_fraction();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return FRAC_BITS'($urandom);
        endcase
    endfunction

    // Drive one request beat and hold it until accepted
    task automatic send_item(input logic op, input logic [FRAC_BITS-1:0] frac,
                             input logic [IDX_W-1:0] c, input logic [IDX_W-1:0] r);
        int gap;
        gap = draw_gap(req_calm);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.op              <= op;
        req_ch.random_fraction <= frac;
        req_ch.col             <= c;
        req_ch.row             <= r;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        grid.note_item(op, frac, c, r);
    endtask

    task automatic feed(input logic [FRAC_BITS-1:0] frac);
        send_item(OP_FEED, frac, IDX_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic read(input logic [IDX_W-1:0] c, input logic [IDX_W-1:0] r);
        send_item(OP_READ, FRAC_BITS'($urandom), c, r);
    endtask

    task automatic put_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        grid.note_config(idx, data);
    endtask

    task automatic write_settings(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows,
                                  input logic jit, input bit sizes, input bit poke_unused);
        if (sizes)
        begin
            put_reg(REG_COLS, cols);
            put_reg(REG_ROWS, rows);
        end
        put_reg(REG_JITTER, CFG_W'(jit));
        if (poke_unused) put_reg(REG_UNUSED, '1);
        cfg_we <= 1'b0;
    endtask

    // Drop valid, wait for every read to return, then let any feed in work finish
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (grid.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows,
                             input logic jit, input bit sizes, input int count,
                             input int feed_pct);
        logic [IDX_W-1:0] c;
        logic [IDX_W-1:0] r;
        wait_idle();
        write_settings(cols, rows, jit, sizes, 1'b0);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < feed_pct)
                feed(pick_fraction());
            else
            begin
                // Mostly aim inside the grid, sometimes anywhere
                if ($urandom_range(0, 3) != 0)
                begin
                    c = IDX_W'($urandom_range(0, grid.cols() - 1));
                    r = IDX_W'($urandom_range(0, grid.rows() - 1));
                end
                else
                begin
                    c = IDX_W'($urandom);
                    r = IDX_W'($urandom);
                end
                if (grid.readable(c, r))
                    read(c, r);
                else
                    feed(pick_fraction());
            end
        end
    endtask

    // Result sink: stall at random, check every beat taken
    initial
    begin
        int gap;
        forever
        begin
            gap = draw_gap(rsp_calm);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            grid.check_point(rsp_ch.point_x, rsp_ch.point_y, rsp_ch.set_complete);
        end
    end

    // Stimulus
    initial
    begin
        req_calm               = 0;
        rsp_calm               = 0;
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= REG_COLS;
        cfg_data               <= '0;
        req_ch.valid           <= 1'b0;
        req_ch.op              <= OP_FEED;
        req_ch.random_fraction <= '0;
        req_ch.col             <= '0;
        req_ch.row             <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 2 x 2 set through fill, both shuffles, completion and restart
        write_settings(5'd2, 5'd2, 1'b1, 1'b1, 1'b1);
        read(4'd15, 4'd15);
        read(4'd2, 4'd0);
        feed(16'h0000);
        feed(16'hFFFF);
        read(4'd0, 4'd0);
        feed(16'h8000);
        feed(16'h0001);
        feed(16'hFFFF);
        feed(16'h0000);
        feed(16'h1234);
        feed(16'hFFFE);
        read(4'd1, 4'd1);
        read(4'd0, 4'd1);
        feed(16'hFFFF);
        feed(16'h0000);
        feed(16'h8000);
        read(4'd1, 4'd0);
        feed(16'hFFFF);
        read(4'd0, 4'd0);
        read(4'd1, 4'd1);
        feed(16'h4321);
        read(4'd0, 4'd0);
        read(4'd0, 4'd15);

        // Random: several sizes, out-of-range sizes, jitter off, jitter-only change
        run_phase(5'd3,  5'd5,  1'b1, 1'b1, 100, 75);
        run_phase(5'd1,  5'd1,  1'b1, 1'b1, 40,  60);
        run_phase(5'd0,  5'd31, 1'b0, 1'b1, 80,  75);
        run_phase(5'd16, 5'd16, 1'b1, 1'b1, 600, 90);
        run_phase(5'd7,  5'd2,  1'b0, 1'b1, 40,  75);
        run_phase(5'd7,  5'd2,  1'b1, 1'b0, 30,  75);
        run_phase(5'd17, 5'd0,  1'b1, 1'b1, 60,  75);
        wait_idle();

        if (grid.errors == 0)
            $display("** multi_jittered_sample_grid_unit: PASSED **");
        else
            $display("** multi_jittered_sample_grid_unit: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(LIMIT_NS);
        $display("** multi_jittered_sample_grid_unit: FAILED **");
        $finish;
    end

endmodule

// ===== multi_jittered_sample_grid_unit.f =====
rtl/core/mjs_pkg.sv
rtl/core/mjs_if.sv
rtl/core/mjs_div.sv
rtl/core/mjs_store.sv
rtl/core/multi_jittered_sample_grid_unit.sv
sim/tb_top.sv
